FILE: rtl/rtcps_pkg.sv
`default_nettype none

package rtcps_pkg;

    localparam int PHASES_DEF     = 16;
    localparam int LEVEL_BITS_DEF = 3;

    localparam int COLOR_W     = 8;
    localparam int OFFSET_W    = 16;
    localparam int GAIN_W      = 20;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 1;
    localparam int PLANE_W     = 16;
    localparam int NUM_PLANES  = 3;

    // Q1.15 colour matrix and chroma weights
    localparam int K_G  = 19235;
    localparam int K_B  = 3736;
    localparam int K_R  = 9798;
    localparam int K_B2 = 29032;
    localparam int K_R2 = 22970;
    localparam int K_U  = 16125;
    localparam int K_V  = 28747;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd22938;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 20'd270664;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LEVEL_OFFSET = 1'b0,
        REG_LEVEL_GAIN   = 1'b1
    } cfg_reg_t;

    // Data handed from cell to cell
    typedef struct packed {
        logic                                valid;
        logic [23:0]                         ybase;   // y_num + 128*offset
        logic [23:0]                         by_n;    // signed B-Y numerator
        logic [23:0]                         ry_n;    // signed R-Y numerator
        logic [16:0]                         err;     // signed Q16 diffusion error
        logic [NUM_PLANES-1:0][PLANE_W-1:0]  planes;
    } bus_t;

    function automatic logic signed [15:0] q30_to_q15(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v < 64'sd0) ? 64'sd0 : ((v + 64'sd16384) >>> 15);
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end
        return r[15:0];
    endfunction

    // Taylor series in Q30, x in 0 .. pi/2
    function automatic logic signed [15:0] sin_q15(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] acc;
        x2  = (x * x) >> 30;
        t   = x;
        acc = $signed(x);
        t   = ((t * x2) >> 30) / 64'd6;
        acc = acc - $signed(t);
        t   = ((t * x2) >> 30) / 64'd20;
        acc = acc + $signed(t);
        t   = ((t * x2) >> 30) / 64'd42;
        acc = acc - $signed(t);
        t   = ((t * x2) >> 30) / 64'd72;
        acc = acc + $signed(t);
        t   = ((t * x2) >> 30) / 64'd110;
        acc = acc - $signed(t);
        return q30_to_q15(acc);
    endfunction

    function automatic logic signed [15:0] cos_q15(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] acc;
        x2  = (x * x) >> 30;
        t   = 64'd1 << 30;
        acc = $signed(t);
        t   = ((t * x2) >> 30) / 64'd2;
        acc = acc - $signed(t);
        t   = ((t * x2) >> 30) / 64'd12;
        acc = acc + $signed(t);
        t   = ((t * x2) >> 30) / 64'd30;
        acc = acc - $signed(t);
        t   = ((t * x2) >> 30) / 64'd56;
        acc = acc + $signed(t);
        t   = ((t * x2) >> 30) / 64'd90;
        acc = acc - $signed(t);
        t   = ((t * x2) >> 30) / 64'd132;
        acc = acc + $signed(t);
        return q30_to_q15(acc);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rtcps_front.sv
`default_nettype none

// Colour matrix: luma base and colour difference numerators
module rtcps_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              enable,
    input  wire logic                              in_valid,
    input  wire logic [rtcps_pkg::COLOR_W-1:0]     red,
    input  wire logic [rtcps_pkg::COLOR_W-1:0]     green,
    input  wire logic [rtcps_pkg::COLOR_W-1:0]     blue,
    input  wire logic [rtcps_pkg::OFFSET_W-1:0]    level_offset,
    output rtcps_pkg::bus_t                        bus_out
);

    logic signed [25:0] red_s;
    logic signed [25:0] green_s;
    logic signed [25:0] blue_s;
    logic signed [25:0] y_num;
    logic signed [25:0] by_num;
    logic signed [25:0] ry_num;
    rtcps_pkg::bus_t    bus_reg;
    rtcps_pkg::bus_t    bus_next;

    always_comb begin
        red_s   = $signed({18'd0, red});
        green_s = $signed({18'd0, green});
        blue_s  = $signed({18'd0, blue});
        y_num   = 26'(rtcps_pkg::K_G) * green_s + 26'(rtcps_pkg::K_B) * blue_s
                + 26'(rtcps_pkg::K_R) * red_s;
        by_num  = 26'(rtcps_pkg::K_B2) * blue_s - 26'(rtcps_pkg::K_G) * green_s
                - 26'(rtcps_pkg::K_R) * red_s;
        ry_num  = 26'(rtcps_pkg::K_R2) * red_s - 26'(rtcps_pkg::K_G) * green_s
                - 26'(rtcps_pkg::K_B) * blue_s;

        bus_next        = '0;
        bus_next.valid  = in_valid;
        bus_next.ybase  = y_num[23:0] + {1'b0, level_offset, 7'd0};
        bus_next.by_n   = by_num[23:0];
        bus_next.ry_n   = ry_num[23:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_reg.valid <= 1'b0;
        end else if (enable) begin
            bus_reg <= bus_next;
        end
    end

    assign bus_out = bus_reg;

endmodule

`default_nettype wire

FILE: rtl/rtcps_cell.sv
`default_nettype none

// One subcarrier phase: chroma products, gain, then error-diffused level.
// Three register stages; everything travels together so the error from
// the previous phase arrives with its own pixel.
module rtcps_cell #(
    parameter int PHASES     = rtcps_pkg::PHASES_DEF,
    parameter int LEVEL_BITS = rtcps_pkg::LEVEL_BITS_DEF,
    parameter int IDX        = 0
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           enable,
    input  wire logic [rtcps_pkg::GAIN_W-1:0]   level_gain,
    input  rtcps_pkg::bus_t                     bus_in,
    output rtcps_pkg::bus_t                     bus_out
);

    localparam int          QUAD = (4 * IDX) / PHASES;
    localparam int          REM  = 4 * IDX - QUAD * PHASES;
    localparam logic [63:0] XQ30 = rtcps_pkg::PI_HALF_Q30 * 64'(REM) / 64'(PHASES);

    localparam logic signed [15:0] S0 = rtcps_pkg::sin_q15(XQ30);
    localparam logic signed [15:0] C0 = rtcps_pkg::cos_q15(XQ30);
    localparam logic signed [15:0] SN = (QUAD % 4 == 0) ? S0 :
                                        (QUAD % 4 == 1) ? C0 :
                                        (QUAD % 4 == 2) ? -S0 : -C0;
    localparam logic signed [15:0] CS = (QUAD % 4 == 0) ? C0 :
                                        (QUAD % 4 == 1) ? -S0 :
                                        (QUAD % 4 == 2) ? -C0 : S0;
    localparam int CU = rtcps_pkg::K_U * int'(SN);
    localparam int CV = rtcps_pkg::K_V * int'(CS);

    localparam bit         HAS_BIT   = (IDX < rtcps_pkg::PLANE_W);
    localparam int         BIT_POS   = HAS_BIT ? (rtcps_pkg::PLANE_W - 1 - IDX) : 0;
    localparam logic [9:0] MAX_LEVEL = 10'((1 << LEVEL_BITS) - 1);

    // stage 1: chroma products
    rtcps_pkg::bus_t    s1_reg;
    logic signed [55:0] pu_reg;
    logic signed [55:0] pu_next;
    logic signed [55:0] pv_reg;
    logic signed [55:0] pv_next;
    // stage 2: gain product
    rtcps_pkg::bus_t    s2_reg;
    logic signed [56:0] tot;
    logic signed [19:0] v_s;
    logic signed [40:0] nprod_reg;
    logic signed [40:0] nprod_next;
    // stage 3: quantiser
    rtcps_pkg::bus_t    s3_reg;
    rtcps_pkg::bus_t    s3_next;
    logic signed [24:0] n_s;
    logic signed [25:0] sum_s;
    logic               neg;
    logic [25:0]        mag;
    logic [9:0]         lvl;
    logic [16:0]        frac;

    always_comb begin
        pu_next = 56'($signed(bus_in.by_n)) * 56'(CU);
        pv_next = 56'($signed(bus_in.ry_n)) * 56'(CV);
    end

    always_comb begin
        tot        = $signed({3'b000, s1_reg.ybase, 30'd0}) + 57'(pu_reg) + 57'(pv_reg);
        v_s        = tot[56:37];   // floor of tot / 2^37
        nprod_next = 41'(v_s) * 41'($signed({1'b0, level_gain}));
    end

    always_comb begin
        n_s   = nprod_reg[40:16];
        sum_s = 26'(n_s) + 26'($signed(s2_reg.err));
        neg   = sum_s[25];
        mag   = neg ? 26'(-sum_s) : 26'(sum_s);
        frac  = {1'b0, mag[15:0]};
        // truncate toward zero, then clip to the DAC range
        if (neg) begin
            lvl = 10'd0;
        end else if (mag[25:16] > MAX_LEVEL) begin
            lvl = MAX_LEVEL;
        end else begin
            lvl = mag[25:16];
        end

        s3_next     = s2_reg;
        s3_next.err = neg ? 17'(-frac) : frac;
        if (HAS_BIT) begin
            for (int j = 0; j < rtcps_pkg::NUM_PLANES; j++) begin
                s3_next.planes[j][BIT_POS] = lvl[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            s2_reg.valid <= 1'b0;
            s3_reg.valid <= 1'b0;
        end else if (enable) begin
            s1_reg <= bus_in;
            s2_reg <= s1_reg;
            s3_reg <= s3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            pu_reg    <= pu_next;
            pv_reg    <= pv_next;
            nprod_reg <= nprod_next;
        end
    end

    assign bus_out = s3_reg;

endmodule

`default_nettype wire

FILE: rtl/rgb_to_composite_phase_samples.sv
`default_nettype none

// RGB to composite subcarrier samples.
// Input: one 8-bit RGB colour per transfer on s_ (valid/ready).
// Output: one transfer per colour on m_, three bit planes holding the DAC
// level of each subcarrier phase, phase 0 in bit 15.
// Pipeline: colour matrix stage, then a chain of PHASES cells (one per
// phase, 3 stages each, the diffusion error passed along), then an output
// register. One colour is taken every cycle while s_ready is high.
// Stall: the chain moves as a whole. While m_valid waits on m_ready the
// chain still advances as long as its last cell holds no result, so input
// keeps flowing into free slots; once the last cell is full as well, s_ready
// drops until the output register is taken.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// default offset (0.35) and gain (4.13). cfg_wr_en writes a register at
// once: index 0 level_offset, index 1 level_gain; write only when idle.
module rgb_to_composite_phase_samples #(
    parameter int PHASES     = rtcps_pkg::PHASES_DEF,
    parameter int LEVEL_BITS = rtcps_pkg::LEVEL_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration
    input  wire logic                                cfg_wr_en,
    input  wire logic [rtcps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [rtcps_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    // colour in
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [rtcps_pkg::COLOR_W-1:0]       s_red,
    input  wire logic [rtcps_pkg::COLOR_W-1:0]       s_green,
    input  wire logic [rtcps_pkg::COLOR_W-1:0]       s_blue,
    // planes out
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [rtcps_pkg::PLANE_W-1:0]            m_plane_bit0,
    output logic [rtcps_pkg::PLANE_W-1:0]            m_plane_bit1,
    output logic [rtcps_pkg::PLANE_W-1:0]            m_plane_bit2
);

    logic [rtcps_pkg::OFFSET_W-1:0] offset_reg;
    logic [rtcps_pkg::OFFSET_W-1:0] offset_next;
    logic [rtcps_pkg::GAIN_W-1:0]   gain_reg;
    logic [rtcps_pkg::GAIN_W-1:0]   gain_next;

    rtcps_pkg::bus_t link [PHASES+1];

    logic chain_en;   // whole chain advances
    logic out_load;   // output register free or being taken

    logic                                               out_valid_reg;
    logic [rtcps_pkg::NUM_PLANES-1:0][rtcps_pkg::PLANE_W-1:0] planes_reg;

    // Configuration registers
    always_comb begin
        offset_next = offset_reg;
        gain_next   = gain_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                rtcps_pkg::REG_LEVEL_OFFSET: begin
                    offset_next = cfg_wr_data[rtcps_pkg::OFFSET_W-1:0];
                end
                rtcps_pkg::REG_LEVEL_GAIN: begin
                    gain_next = cfg_wr_data[rtcps_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= rtcps_pkg::OFFSET_RESET;
            gain_reg   <= rtcps_pkg::GAIN_RESET;
        end else begin
            offset_reg <= offset_next;
            gain_reg   <= gain_next;
        end
    end

    // Flow control: a held result only blocks the chain when the last cell
    // has one too.
    assign out_load = !out_valid_reg || m_ready;
    assign chain_en = out_load || !link[PHASES].valid;
    assign s_ready  = chain_en;

    rtcps_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .enable       (chain_en),
        .in_valid     (s_valid),
        .red          (s_red),
        .green        (s_green),
        .blue         (s_blue),
        .level_offset (offset_reg),
        .bus_out      (link[0])
    );

    for (genvar i = 0; i < PHASES; i++) begin : g_cell
        rtcps_cell #(
            .PHASES     (PHASES),
            .LEVEL_BITS (LEVEL_BITS),
            .IDX        (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .enable     (chain_en),
            .level_gain (gain_reg),
            .bus_in     (link[i]),
            .bus_out    (link[i+1])
        );
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= link[PHASES].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            planes_reg <= link[PHASES].planes;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_plane_bit0 = planes_reg[0];
    assign m_plane_bit1 = planes_reg[1];
    assign m_plane_bit2 = planes_reg[2];

endmodule

`default_nettype wire

FILE: rtl/rtcps_checker.sv
`default_nettype none

module rtcps_checker #(
    parameter int PHASES     = rtcps_pkg::PHASES_DEF,
    parameter int LEVEL_BITS = rtcps_pkg::LEVEL_BITS_DEF
) (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_valid,
    input wire logic                                s_ready,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic [rtcps_pkg::PLANE_W-1:0]       m_plane_bit0,
    input wire logic [rtcps_pkg::PLANE_W-1:0]       m_plane_bit1,
    input wire logic [rtcps_pkg::PLANE_W-1:0]       m_plane_bit2
);

    localparam logic [rtcps_pkg::PLANE_W-1:0] UNUSED_BITS =
        (PHASES >= rtcps_pkg::PLANE_W) ? '0 : ({rtcps_pkg::PLANE_W{1'b1}} >> PHASES);

    // held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_plane_bit0)
            && $stable(m_plane_bit1) && $stable(m_plane_bit2))
        else $error("result changed while stalled");

    // reset empties the output
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid after reset");

    // input only blocked by a stalled result
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("s_ready low without output stall");

    // phases beyond the count leave no bits
    a_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_plane_bit0 | m_plane_bit1 | m_plane_bit2) & UNUSED_BITS) == '0)
        else $error("bit set for a missing phase");

    // planes above the level width stay clear
    a_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (LEVEL_BITS < 3) |-> m_plane_bit2 == '0
            && (LEVEL_BITS >= 2 || m_plane_bit1 == '0))
        else $error("plane above level width set");

endmodule

bind rgb_to_composite_phase_samples rtcps_checker #(
    .PHASES     (PHASES),
    .LEVEL_BITS (LEVEL_BITS)
) u_rtcps_checker (.*);

`default_nettype wire
